// ===== hw/rtl/imh_pkg.sv =====
package imh_pkg;

  // Sizes of the heap and its fields.
  localparam int unsigned CAP       = 1024;
  localparam int unsigned ID_BITS   = 10;
  localparam int unsigned SLOT_BITS = 10;
  localparam int unsigned CNT_BITS  = 11;
  localparam int unsigned KEY_BITS  = 20;

  // Operation codes; the last one is unused and changes nothing.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP    = 2'd1;
  localparam logic [1:0] ACT_ERASE  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_ABSENT   = 3'd2;
  localparam logic [2:0] STAT_LOWERED  = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_CMP, S_UP, S_UP1, S_UP2, S_UPEND,
    S_PKEY, S_LIFT, S_LIFT1, S_POP, S_POP1, S_POP2,
    S_DN, S_DN1, S_DN2, S_DN3, S_DNEND, S_TOP, S_TOP1, S_TOP2, S_DONE
  } state_t;

endpackage

// ===== hw/rtl/imh_if.sv =====
// Request channel: one heap operation per beat.
interface imh_req_if;
  import imh_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [ID_BITS-1:0]  item_id;
  logic [KEY_BITS-1:0] key;
  modport source (output valid, action, item_id, key, input ready);
  modport sink (input valid, action, item_id, key, output ready);
endinterface

// Response channel: one result per beat.
interface imh_rsp_if;
  import imh_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [ID_BITS-1:0]  popped_id;
  logic [KEY_BITS-1:0] popped_key;
  logic [ID_BITS-1:0]  top_id;
  logic [KEY_BITS-1:0] top_key;
  logic [CNT_BITS-1:0] count;
  logic                empty_res;
  modport source (output valid, status, popped_id, popped_key, top_id, top_key, count,
                  empty_res, input ready);
  modport sink (input valid, status, popped_id, popped_key, top_id, top_key, count,
                empty_res, output ready);
endinterface

// ===== hw/rtl/indexed_max_heap_unit.sv =====
// Channel | Dir | Beat contents
// req     | in  | action, item_id, key
// rsp     | out | status, popped_id, popped_key, top_id, top_key, count, empty_res
//
// One operation at a time; a sequencer drives one read per RAM per cycle.
// Sift-up, sift-down and the erase lift walk the tree one level at a time, around the
// lookup, removal and top readback steps.
// After reset a clearing pass marks every id absent; req.ready is low.
// A finished result waits in the output register while the next beat is taken.
module indexed_max_heap_unit
  import imh_pkg::*;
(
  input logic     clk,
  input logic     rst,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);

  state_t st, st_next;

  logic [1:0]           act;
  logic [ID_BITS-1:0]   id_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [CNT_BITS-1:0]  cnt;
  logic [2:0]           status;
  logic [ID_BITS-1:0]   pid;
  logic [KEY_BITS-1:0]  pkey;
  logic [ID_BITS-1:0]   x_id;
  logic [ID_BITS-1:0]   m_id;
  logic [KEY_BITS-1:0]  m_key;
  logic [SLOT_BITS-1:0] hole;
  logic [ID_BITS-1:0]   ca;
  logic [KEY_BITS-1:0]  ka;
  logic                 has_b;
  logic [ID_BITS-1:0]   tid;
  logic [KEY_BITS-1:0]  tkey;
  logic [SLOT_BITS-1:0] clr;

  // RAM ports.
  logic                 s_we, p_we, k_we;
  logic [SLOT_BITS-1:0] s_wa, s_ra;
  logic [ID_BITS-1:0]   s_wd, s_rd;
  logic [ID_BITS-1:0]   p_wa, p_ra;
  logic [SLOT_BITS:0]   p_wd, p_rd;
  logic [ID_BITS-1:0]   k_wa, k_ra;
  logic [KEY_BITS-1:0]  k_wd, k_rd;

  // Slot to id, id to {present, slot}, id to key.
  imh_ram #(.WIDTH(ID_BITS), .DEPTH(CAP)) u_slot (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  imh_ram #(.WIDTH(SLOT_BITS + 1), .DEPTH(CAP)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  imh_ram #(.WIDTH(KEY_BITS), .DEPTH(CAP)) u_key (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

  // Tree index arithmetic.
  logic [SLOT_BITS-1:0] parent;
  logic [CNT_BITS-1:0]  lc, rc, cnt_dec;
  logic                 take_b;
  logic [ID_BITS-1:0]   cid;
  logic [KEY_BITS-1:0]  ckey;
  logic [SLOT_BITS-1:0] cidx;
  logic                 out_load;

  assign parent  = (hole - SLOT_BITS'(1)) >> 1;
  assign lc      = {hole, 1'b1};
  assign rc      = lc + CNT_BITS'(1);
  assign cnt_dec = cnt - CNT_BITS'(1);
  assign take_b  = has_b && (k_rd > ka);
  assign cid     = take_b ? s_rd : ca;
  assign ckey    = take_b ? k_rd : ka;
  assign cidx    = take_b ? rc[SLOT_BITS-1:0] : lc[SLOT_BITS-1:0];
  assign out_load = (st == S_DONE) && (!rsp.valid || rsp.ready);

  assign req.ready = (st == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // Next state and RAM control.
  always_comb begin
    st_next = st;
    s_we = 1'b0; s_wa = hole; s_wd = m_id; s_ra = '0;
    p_we = 1'b0; p_wa = m_id; p_wd = {1'b1, hole}; p_ra = req.item_id;
    k_we = 1'b0; k_wa = id_r; k_wd = key_r; k_ra = id_r;
    unique case (st)
      S_CLEAR: begin
        p_we = 1'b1; p_wa = clr; p_wd = '0;
        if (clr == SLOT_BITS'(CAP - 1)) st_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) st_next = S_LOOK;
      end
      S_LOOK: begin
        case (act)
          ACT_INSERT: begin
            if (p_rd[SLOT_BITS]) begin
              st_next = S_CMP;
            end else if (cnt[CNT_BITS-1]) begin
              st_next = S_TOP;
            end else begin
              k_we = 1'b1;
              st_next = S_UP;
            end
          end
          ACT_POP: begin
            k_ra = s_rd;
            st_next = (cnt == '0) ? S_TOP : S_PKEY;
          end
          ACT_ERASE: begin
            st_next = p_rd[SLOT_BITS] ? S_PKEY : S_TOP;
          end
          default: st_next = S_TOP;
        endcase
      end
      S_CMP: begin
        if (key_r < k_rd) begin
          st_next = S_TOP;
        end else begin
          k_we = 1'b1;
          st_next = S_UP;
        end
      end
      S_UP: begin
        s_ra = parent;
        st_next = (hole == '0) ? S_UPEND : S_UP1;
      end
      S_UP1: begin
        k_ra = s_rd;
        st_next = S_UP2;
      end
      S_UP2: begin
        if (k_rd < m_key) begin
          s_we = 1'b1; s_wd = ca;
          p_we = 1'b1; p_wa = ca;
          st_next = S_UP;
        end else begin
          st_next = S_UPEND;
        end
      end
      S_UPEND: begin
        s_we = 1'b1; p_we = 1'b1;
        st_next = S_TOP;
      end
      S_PKEY: begin
        st_next = (act == ACT_ERASE) ? S_LIFT : S_POP;
      end
      S_LIFT: begin
        s_ra = parent;
        st_next = (hole == '0) ? S_POP : S_LIFT1;
      end
      S_LIFT1: begin
        s_we = 1'b1; s_wd = s_rd;
        p_we = 1'b1; p_wa = s_rd;
        st_next = S_LIFT;
      end
      S_POP: begin
        p_we = 1'b1; p_wa = x_id; p_wd = '0;
        s_ra = cnt_dec[SLOT_BITS-1:0];
        st_next = (cnt_dec == '0) ? S_TOP : S_POP1;
      end
      S_POP1: begin
        k_ra = s_rd;
        st_next = S_POP2;
      end
      S_POP2: begin
        st_next = S_DN;
      end
      S_DN: begin
        s_ra = lc[SLOT_BITS-1:0];
        st_next = (lc >= cnt) ? S_DNEND : S_DN1;
      end
      S_DN1: begin
        k_ra = s_rd;
        s_ra = rc[SLOT_BITS-1:0];
        st_next = S_DN2;
      end
      S_DN2: begin
        // Keep the right child's id on the read port for the compare.
        k_ra = s_rd;
        s_ra = rc[SLOT_BITS-1:0];
        st_next = S_DN3;
      end
      S_DN3: begin
        if (m_key >= ckey) begin
          st_next = S_DNEND;
        end else begin
          s_we = 1'b1; s_wd = cid;
          p_we = 1'b1; p_wa = cid;
          st_next = S_DN;
        end
      end
      S_DNEND: begin
        s_we = 1'b1; p_we = 1'b1;
        st_next = S_TOP;
      end
      S_TOP: begin
        s_ra = '0;
        st_next = (cnt == '0) ? S_DONE : S_TOP1;
      end
      S_TOP1: begin
        k_ra = s_rd;
        st_next = S_TOP2;
      end
      S_TOP2: begin
        st_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      clr <= '0;
    end else begin
      if (st == S_CLEAR) clr <= clr + SLOT_BITS'(1);
      if (st == S_LOOK && act == ACT_INSERT && !p_rd[SLOT_BITS] && !cnt[CNT_BITS-1]) begin
        cnt <= cnt + CNT_BITS'(1);
      end
      if (st == S_POP) cnt <= cnt_dec;
    end
  end

  // Operation datapath.
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        act <= req.action; id_r <= req.item_id; key_r <= req.key;
        status <= STAT_OK; pid <= '0; pkey <= '0;
        tid <= '0; tkey <= '0;
      end
      S_LOOK: begin
        m_id <= id_r; m_key <= key_r;
        x_id <= id_r;
        case (act)
          ACT_INSERT: begin
            hole <= p_rd[SLOT_BITS-1:0];
            if (!p_rd[SLOT_BITS]) begin
              hole <= cnt[SLOT_BITS-1:0];
              if (cnt[CNT_BITS-1]) status <= STAT_FULL;
            end
          end
          ACT_POP: begin
            hole <= '0;
            x_id <= s_rd;
            if (cnt == '0) status <= STAT_EMPTY;
          end
          ACT_ERASE: begin
            hole <= p_rd[SLOT_BITS-1:0];
            if (!p_rd[SLOT_BITS]) status <= STAT_ABSENT;
          end
          default: hole <= '0;
        endcase
      end
      S_CMP: if (key_r < k_rd) status <= STAT_LOWERED;
      S_UP1: ca <= s_rd;
      S_UP2: if (k_rd < m_key) hole <= parent;
      S_PKEY: begin
        pid <= x_id; pkey <= k_rd;
      end
      S_LIFT1: hole <= parent;
      S_POP: hole <= '0;
      S_POP1: m_id <= s_rd;
      S_POP2: m_key <= k_rd;
      S_DN1: begin
        ca <= s_rd;
        has_b <= rc < cnt;
      end
      S_DN2: ka <= k_rd;
      S_DN3: if (m_key < ckey) hole <= cidx;
      S_TOP1: tid <= s_rd;
      S_TOP2: tkey <= k_rd;
      default: ;
    endcase
  end

  // Output register; it holds a result until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status     <= status;
      rsp.popped_id  <= pid;
      rsp.popped_key <= pkey;
      rsp.top_id     <= tid;
      rsp.top_key    <= tkey;
      rsp.count      <= cnt;
      rsp.empty_res  <= (cnt == '0);
    end
  end

`ifndef SYNTHESIS
  // The count never exceeds the capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_BITS'(CAP)) else $error("heap count beyond capacity");

  // The clearing pass runs only once after reset.
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    st != S_CLEAR |=> st != S_CLEAR) else $error("clearing pass re-entered");

  // A valid result reports empty exactly when its count is zero.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.empty_res == (rsp.count == '0))) else $error("empty flag mismatch");

  // Sift-down only compares with a child inside the heap.
  a_dn_child: assert property (@(posedge clk) disable iff (rst)
    st == S_DN3 |-> lc < cnt) else $error("sift-down child out of range");
`endif

endmodule

// ===== hw/rtl/imh_ram.sv =====
// Simple dual-port RAM: one write and one registered read per cycle.
module imh_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
